### hw/rtl/ssplit_pkg.sv
// Shared constants and types of the separator string splitter.
package ssplit_pkg;

    // Separator window
    localparam int MAX_SEPARATOR_LEN = 8;
    localparam int SEP_IW            = (MAX_SEPARATOR_LEN > 1) ? $clog2(MAX_SEPARATOR_LEN) : 1;
    localparam int LEN_W             = 4;
    localparam int WINDOW_BYTES      = 8;

    // String positions
    localparam int POS_W                   = 16;
    localparam logic [POS_W-1:0] MAX_STRING_LEN = 16'hFFFF;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Configuration register indexes
    localparam logic [7:0] REG_SEPARATOR_BYTES  = 8'd0;
    localparam logic [7:0] REG_SEPARATOR_LENGTH = 8'd1;
    localparam logic [7:0] REG_LIMIT_ENABLED    = 8'd2;
    localparam logic [7:0] REG_PIECE_LIMIT      = 8'd3;

    // One result item
    typedef struct packed {
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] length;
        logic             last;
        logic             overflow;
    } result_t;

    // Results written into the queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

### hw/rtl/separator_string_splitter.sv
// Top level of the separator string splitter.
//
// Input stream: one byte per transaction. s_tdata carries the byte, s_tuser
// flags whether the transaction holds a byte, s_tlast ends the string (after
// the byte, if any). Output stream: one piece per transaction with start and
// length in m_tdata, m_tlast on the final piece of a string and m_tuser set
// when the string ran past the position range.
// The configuration channel writes one register per transaction and is
// always ready; write it only while no string is in flight.
// Throughput: one byte per cycle while s_tready is high. The separator
// compare runs through a row of byte cells in the same cycle the byte is
// accepted, so a result enters the four-entry result queue at the accepting
// edge and shows on m_* after the results ahead of it. An item giving two
// results (split, final piece) leaves as two transactions. s_tready is
// held low while the queue has fewer than two free entries, so a stalled
// receiver fills the queue, then stops the input side; nothing is dropped.
// Reset clears the string state, the queue and loads the register defaults
// (separator comma, length one, no limit).
module separator_string_splitter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic [0:0]  s_tuser,   // [0] has_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] piece_start, [31:16] piece_length
    output logic [0:0]  m_tuser,   // [0] overflow
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int N = ssplit_pkg::MAX_SEPARATOR_LEN;
    localparam int PW = ssplit_pkg::POS_W;

    // Configuration registers
    logic [63:0]                  sep_bytes_reg;
    logic [ssplit_pkg::LEN_W-1:0] sep_len_reg;
    logic                         limit_en_reg;
    logic [15:0]                  piece_limit_reg;

    // String state
    logic [PW-1:0]                position_reg;
    logic [PW-1:0]                position_next;
    logic [PW-1:0]                cur_start_reg;
    logic [PW-1:0]                cur_start_next;
    logic [ssplit_pkg::LEN_W-1:0] bip_reg;
    logic [ssplit_pkg::LEN_W-1:0] bip_next;
    logic [15:0]                  splits_left_reg;
    logic [15:0]                  splits_left_next;
    logic                         overflow_reg;
    logic                         overflow_next;

    logic                         accept;
    logic                         has_byte;
    logic                         eos;
    logic [ssplit_pkg::LEN_W-1:0] eff_len;
    logic [15:0]                  splits_eff;
    logic                         at_max;
    logic [PW-1:0]                pos_upd;
    logic                         ovf_upd;
    logic [ssplit_pkg::LEN_W-1:0] bip_upd;
    logic                         split;
    logic [PW:0]                  idx1;
    logic [PW:0]                  match_start;
    logic [PW-1:0]                split_len;
    logic [PW-1:0]                split_next;
    logic [PW-1:0]                start_after;
    logic [PW-1:0]                final_len;
    logic                         space_ok;

    ssplit_pkg::result_t          split_res;
    ssplit_pkg::result_t          final_res;
    ssplit_pkg::result_t          out_res;
    ssplit_pkg::push_t            push;

    logic [7:0]                   sep_arr   [N];
    logic [7:0]                   cell_byte [N];
    logic [N:0]                   hit_chain;

    assign accept   = s_tvalid & s_tready;
    assign has_byte = s_tuser[0];
    assign eos      = s_tlast;
    assign s_tready = space_ok;
    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_bytes_reg   <= 64'd44;
            sep_len_reg     <= 4'd1;
            limit_en_reg    <= 1'b0;
            piece_limit_reg <= 16'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ssplit_pkg::REG_SEPARATOR_BYTES:  sep_bytes_reg   <= cfg_data;
                ssplit_pkg::REG_SEPARATOR_LENGTH: sep_len_reg     <= cfg_data[3:0];
                ssplit_pkg::REG_LIMIT_ENABLED:    limit_en_reg    <= cfg_data[0];
                ssplit_pkg::REG_PIECE_LIMIT:      piece_limit_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Clamp the separator length into the supported range
    always_comb
    begin
        if (sep_len_reg == '0)
        begin
            eff_len = ssplit_pkg::LEN_W'(1);
        end
        else if (sep_len_reg > ssplit_pkg::LEN_W'(N))
        begin
            eff_len = ssplit_pkg::LEN_W'(N);
        end
        else
        begin
            eff_len = sep_len_reg;
        end
    end

    // Row of window cells, newest byte enters the last cell
    assign hit_chain[0] = 1'b1;

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_cell
            logic [4:0]                pos_sum;
            logic                      cmp_en;
            logic [ssplit_pkg::SEP_IW-1:0] sep_idx;
            logic [7:0]                in_byte;

            assign sep_arr[k] = sep_bytes_reg[8*k +: 8];
            assign pos_sum    = 5'(k) + {1'b0, eff_len};
            assign cmp_en     = (pos_sum >= 5'(N));
            assign sep_idx    = ssplit_pkg::SEP_IW'(pos_sum - 5'(N));

            if (k == N - 1)
            begin : g_head
                assign in_byte = s_tdata;
            end
            else
            begin : g_body
                assign in_byte = cell_byte[k+1];
            end

            ssplit_cell u_cell (
                .clk      (clk),
                .shift    (accept & has_byte),
                .in_byte  (in_byte),
                .sep_byte (sep_arr[sep_idx]),
                .cmp_en   (cmp_en),
                .hit_in   (hit_chain[k]),
                .byte_q   (cell_byte[k]),
                .hit_out  (hit_chain[k+1])
            );
        end
    endgenerate

    // Split decision and piece arithmetic
    always_comb
    begin
        splits_eff = (position_reg == '0) ? piece_limit_reg : splits_left_reg;
        at_max     = (position_reg == ssplit_pkg::MAX_STRING_LEN);
        pos_upd    = (has_byte && !at_max) ? position_reg + PW'(1) : position_reg;
        ovf_upd    = overflow_reg | (has_byte & at_max);
        if (has_byte && bip_reg < ssplit_pkg::LEN_W'(ssplit_pkg::WINDOW_BYTES))
        begin
            bip_upd = bip_reg + ssplit_pkg::LEN_W'(1);
        end
        else
        begin
            bip_upd = bip_reg;
        end
        split = has_byte & (bip_upd >= eff_len) & hit_chain[N]
                & (~limit_en_reg | (splits_eff != 16'd0));

        idx1        = {1'b0, position_reg} + (PW+1)'(1);
        match_start = idx1 - (PW+1)'(eff_len);
        if (idx1 >= (PW+1)'(eff_len) && match_start >= {1'b0, cur_start_reg})
        begin
            split_len = PW'(match_start - {1'b0, cur_start_reg});
        end
        else
        begin
            split_len = '0;
        end
        split_next  = (idx1 > {1'b0, ssplit_pkg::MAX_STRING_LEN})
                      ? ssplit_pkg::MAX_STRING_LEN : idx1[PW-1:0];
        start_after = split ? split_next : cur_start_reg;
        final_len   = (pos_upd >= start_after) ? pos_upd - start_after : '0;

        split_res.start    = cur_start_reg;
        split_res.length   = split_len;
        split_res.last     = 1'b0;
        split_res.overflow = ovf_upd;
        final_res.start    = start_after;
        final_res.length   = final_len;
        final_res.last     = 1'b1;
        final_res.overflow = ovf_upd;
    end

    // Hand results to the queue
    always_comb
    begin
        push.count  = accept ? (2'(split) + 2'(eos)) : 2'd0;
        push.first  = split ? split_res : final_res;
        push.second = final_res;
    end

    // Advance string state; clear it after the final piece
    always_comb
    begin
        position_next    = position_reg;
        cur_start_next   = cur_start_reg;
        bip_next         = bip_reg;
        splits_left_next = splits_left_reg;
        overflow_next    = overflow_reg;
        if (accept)
        begin
            if (eos)
            begin
                position_next    = '0;
                cur_start_next   = '0;
                bip_next         = '0;
                splits_left_next = '0;
                overflow_next    = 1'b0;
            end
            else if (has_byte)
            begin
                position_next    = pos_upd;
                cur_start_next   = start_after;
                bip_next         = split ? '0 : bip_upd;
                splits_left_next = (split && limit_en_reg) ? splits_eff - 16'd1 : splits_eff;
                overflow_next    = ovf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= '0;
            cur_start_reg   <= '0;
            bip_reg         <= '0;
            splits_left_reg <= '0;
            overflow_reg    <= 1'b0;
        end
        else
        begin
            position_reg    <= position_next;
            cur_start_reg   <= cur_start_next;
            bip_reg         <= bip_next;
            splits_left_reg <= splits_left_next;
            overflow_reg    <= overflow_next;
        end
    end

    ssplit_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {out_res.length, out_res.start};
    assign m_tuser = out_res.overflow;
    assign m_tlast = out_res.last;

    // String state is back at rest after an end of string
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        accept && eos |=> position_reg == '0 && splits_left_reg == '0 && !overflow_reg)
        else $error("string state not cleared after end of string");

    // The current piece never starts beyond the bytes received
    a_start_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_start_reg <= position_reg)
        else $error("piece start past position");

    // An end of string always queues a final piece
    a_final_pushed: assert property (@(posedge clk) disable iff (!rst_n)
        accept && eos |-> (push.count == 2'd1 && push.first.last)
                          || (push.count == 2'd2 && push.second.last && !push.first.last))
        else $error("end of string without final piece");

    // Byte count inside a piece saturates at the window size
    a_bip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bip_reg <= ssplit_pkg::LEN_W'(ssplit_pkg::WINDOW_BYTES))
        else $error("bytes in piece out of range");

endmodule

### hw/rtl/ssplit_cell.sv
// One byte cell of the separator match window.
module ssplit_cell (
    input  logic       clk,
    input  logic       shift,
    input  logic [7:0] in_byte,
    input  logic [7:0] sep_byte,
    input  logic       cmp_en,
    input  logic       hit_in,
    output logic [7:0] byte_q,
    output logic       hit_out
);

    logic [7:0] byte_reg;

    // Take the neighbor's byte on each accepted byte
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= in_byte;
        end
    end

    assign byte_q = byte_reg;

    // Compare the byte this cell will hold against its separator byte
    assign hit_out = hit_in & (~cmp_en | (in_byte == sep_byte));

endmodule

### hw/rtl/ssplit_fifo.sv
// Small result queue that takes up to two results per cycle and returns one.
module ssplit_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ssplit_pkg::push_t    push,
    output logic                 space_ok,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ssplit_pkg::result_t  out_data
);

    ssplit_pkg::result_t mem_reg [ssplit_pkg::FIFO_DEPTH];

    logic [ssplit_pkg::FIFO_AW-1:0] wptr_reg;
    logic [ssplit_pkg::FIFO_AW-1:0] wptr_next;
    logic [ssplit_pkg::FIFO_AW-1:0] rptr_reg;
    logic [ssplit_pkg::FIFO_AW-1:0] rptr_next;
    logic [ssplit_pkg::FIFO_AW:0]   count_reg;
    logic [ssplit_pkg::FIFO_AW:0]   count_next;
    logic [ssplit_pkg::FIFO_AW-1:0] wptr_second;
    logic                           pop;

    assign out_valid   = (count_reg != '0);
    assign out_data    = mem_reg[rptr_reg];
    assign pop         = out_valid & out_ready;
    assign space_ok    = (count_reg <= (ssplit_pkg::FIFO_AW+1)'(ssplit_pkg::FIFO_DEPTH - 2));
    assign wptr_second = wptr_reg + ssplit_pkg::FIFO_AW'(1);

    // Advance pointers and occupancy
    always_comb
    begin
        wptr_next  = wptr_reg + ssplit_pkg::FIFO_AW'(push.count);
        rptr_next  = pop ? rptr_reg + ssplit_pkg::FIFO_AW'(1) : rptr_reg;
        count_next = count_reg + (ssplit_pkg::FIFO_AW+1)'(push.count)
                     - (ssplit_pkg::FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Store the results of this cycle
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wptr_second] <= push.second;
        end
    end

endmodule
